>>> rtl/core/diode_envelope_detector_step_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the diode envelope detector
// Two property forms, both clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DIODE_ENVELOPE_DETECTOR_STEP_ASSERT_SVH
`define DIODE_ENVELOPE_DETECTOR_STEP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define DED_ASSERT_IMP(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);
// Next-cycle implication
`define DED_ASSERT_NXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);
`else
`define DED_ASSERT_IMP(lbl, a, c, msg)
`define DED_ASSERT_NXT(lbl, a, c, msg)
`endif

`endif

>>> rtl/core/ded_pkg.sv
// ----------------------------------------------------------------------------
// ded_pkg
// Register indexes, datapath select codes and controller command types.
// ----------------------------------------------------------------------------
package ded_pkg;

    localparam int DROP_BITS      = 35;
    localparam int COEF_BITS      = 32;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 35;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_DROP         = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NODE1_LEAK   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NODE1_COUPLE = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NODE2_CHARGE = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NODE2_LOAD   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NODE3_DECAY  = 3'd5;

    // Coefficient reset values
    localparam logic [COEF_BITS-1:0] NODE1_LEAK_RESET   = 32'd85899;
    localparam logic [COEF_BITS-1:0] NODE1_COUPLE_RESET = 32'd4295;
    localparam logic [COEF_BITS-1:0] NODE2_CHARGE_RESET = 32'd42950;
    localparam logic [COEF_BITS-1:0] NODE2_LOAD_RESET   = 32'd4295;
    localparam logic [COEF_BITS-1:0] NODE3_DECAY_RESET  = 32'd8590;

    // Multiplier operand: voltage or voltage difference
    localparam logic [1:0] DIFF_N1  = 2'd0;
    localparam logic [1:0] DIFF_N12 = 2'd1;
    localparam logic [1:0] DIFF_N3  = 2'd2;

    // Multiplier operand: coefficient
    localparam logic [2:0] CSEL_LEAK   = 3'd0;
    localparam logic [2:0] CSEL_COUPLE = 3'd1;
    localparam logic [2:0] CSEL_CHARGE = 3'd2;
    localparam logic [2:0] CSEL_LOAD   = 3'd3;
    localparam logic [2:0] CSEL_DECAY  = 3'd4;

    // Accumulator load
    localparam logic [1:0] ACC_HOLD  = 2'd0;
    localparam logic [1:0] ACC_START = 2'd1;
    localparam logic [1:0] ACC_N2    = 2'd2;
    localparam logic [1:0] ACC_N3    = 2'd3;

    // Saturate accumulator into a node
    localparam logic [1:0] COMMIT_NONE = 2'd0;
    localparam logic [1:0] COMMIT_N1   = 2'd1;
    localparam logic [1:0] COMMIT_N2   = 2'd2;
    localparam logic [1:0] COMMIT_N3   = 2'd3;

    typedef struct packed {
        logic       capture;
        logic [1:0] acc_sel;
        logic       mul_go;
        logic       mul_sub;
        logic [1:0] dsel;
        logic [2:0] csel;
        logic [1:0] commit;
    } cmd_t;

    typedef struct packed {
        logic on;
        logic out_busy;
    } stat_t;

endpackage

>>> rtl/core/ded_sample_if.sv
// ----------------------------------------------------------------------------
// ded_sample_if
// Input sample channel: valid, ready and one signed voltage sample.
// ----------------------------------------------------------------------------
interface ded_sample_if #(
    parameter int VOLTAGE_BITS = 40
);
    logic                           valid;
    logic                           ready;
    logic signed [VOLTAGE_BITS-1:0] am_sample;

    modport source (output valid, output am_sample, input ready);
    modport sink   (input valid, input am_sample, output ready);
endinterface

>>> rtl/core/ded_result_if.sv
// ----------------------------------------------------------------------------
// ded_result_if
// Result channel: valid, ready, three node voltages and the diode flag.
// ----------------------------------------------------------------------------
interface ded_result_if #(
    parameter int VOLTAGE_BITS = 40
);
    logic                           valid;
    logic                           ready;
    logic signed [VOLTAGE_BITS-1:0] node1_out;
    logic signed [VOLTAGE_BITS-1:0] node2_out;
    logic signed [VOLTAGE_BITS-1:0] node3_out;
    logic                           conducting;

    modport source (output valid, output node1_out, output node2_out,
                    output node3_out, output conducting, input ready);
    modport sink   (input valid, input node1_out, input node2_out,
                    input node3_out, input conducting, output ready);
endinterface

>>> rtl/core/ded_ctrl.sv
// ----------------------------------------------------------------------------
// ded_ctrl
// Step sequencer: issues multiplies, accumulator loads and node commits.
// ----------------------------------------------------------------------------
`include "diode_envelope_detector_step_assert.svh"

module ded_ctrl
    import ded_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t status,
    output cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_N1A   = 4'd1;
    localparam logic [3:0] S_N1B   = 4'd2;
    localparam logic [3:0] S_N1W   = 4'd3;
    localparam logic [3:0] S_N1SAT = 4'd4;
    localparam logic [3:0] S_N2A   = 4'd5;
    localparam logic [3:0] S_N2W   = 4'd6;
    localparam logic [3:0] S_N2SAT = 4'd7;
    localparam logic [3:0] S_N3A   = 4'd8;
    localparam logic [3:0] S_N3W   = 4'd9;
    localparam logic [3:0] S_N3SAT = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.acc_sel = ACC_HOLD;
        cmd.commit  = COMMIT_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    cmd.acc_sel = ACC_START;
                    state_next  = status.on ? S_N1SAT : S_N1A;
                end
            end
            S_N1A:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sub = 1'b1;
                cmd.dsel    = DIFF_N1;
                cmd.csel    = CSEL_LEAK;
                state_next  = S_N1B;
            end
            S_N1B:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sub = 1'b1;
                cmd.dsel    = DIFF_N12;
                cmd.csel    = CSEL_COUPLE;
                state_next  = S_N1W;
            end
            S_N1W:
            begin
                state_next = S_N1SAT;
            end
            S_N1SAT:
            begin
                cmd.commit  = COMMIT_N1;
                cmd.acc_sel = ACC_N2;
                cmd.mul_go  = 1'b1;
                cmd.mul_sub = 1'b1;
                cmd.dsel    = DIFF_N3;
                cmd.csel    = CSEL_LOAD;
                state_next  = S_N2A;
            end
            S_N2A:
            begin
                cmd.mul_go = 1'b1;
                cmd.dsel   = DIFF_N12;
                cmd.csel   = CSEL_CHARGE;
                state_next = S_N2W;
            end
            S_N2W:
            begin
                state_next = S_N2SAT;
            end
            S_N2SAT:
            begin
                cmd.commit  = COMMIT_N2;
                cmd.acc_sel = ACC_N3;
                cmd.mul_go  = 1'b1;
                cmd.mul_sub = 1'b1;
                cmd.dsel    = DIFF_N3;
                cmd.csel    = CSEL_DECAY;
                state_next  = S_N3A;
            end
            S_N3A:
            begin
                cmd.mul_go = 1'b1;
                cmd.dsel   = DIFF_N12;
                cmd.csel   = CSEL_CHARGE;
                state_next = S_N3W;
            end
            S_N3W:
            begin
                state_next = S_N3SAT;
            end
            S_N3SAT:
            begin
                // hold until the output register is free
                if (!status.out_busy)
                begin
                    cmd.commit = COMMIT_N3;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `DED_ASSERT_NXT(a_on_skips_decay, in_valid && in_ready && status.on, state_reg == S_N1SAT, "conducting step did not go straight to node 1 commit")
    `DED_ASSERT_NXT(a_off_decays, in_valid && in_ready && !status.on, state_reg == S_N1A, "non-conducting step skipped node 1 decay")
    `DED_ASSERT_NXT(a_stall_holds, (state_reg == S_N3SAT) && status.out_busy, state_reg == S_N3SAT, "left final commit while output stalled")

endmodule

>>> rtl/core/ded_datapath.sv
// ----------------------------------------------------------------------------
// ded_datapath
// Node registers, coefficient registers, split multiplier, accumulator,
// saturation and output register.
// ----------------------------------------------------------------------------
`include "diode_envelope_detector_step_assert.svh"

module ded_datapath
    import ded_pkg::*;
#(
    parameter int VOLTAGE_BITS  = 40,
    parameter int FRACTION_BITS = 32
)(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           write_en,
    input  logic [CFG_INDEX_BITS-1:0]      reg_index,
    input  logic [CFG_DATA_BITS-1:0]       write_data,
    input  logic signed [VOLTAGE_BITS-1:0] am_sample,
    input  cmd_t                           cmd,
    output stat_t                          status,
    ded_result_if.source                   results
);

    localparam int DW  = VOLTAGE_BITS + 1;
    localparam int XW  = (DW > 33) ? DW : 33;
    localparam int HW  = XW - COEF_BITS;
    localparam int PHW = HW + COEF_BITS + 1;
    localparam int AW  = ((VOLTAGE_BITS > DROP_BITS) ? VOLTAGE_BITS : DROP_BITS) + 3;

    localparam logic [63:0] DROP_RAW = (64'd7 << FRACTION_BITS) / 64'd10;
    localparam logic [DROP_BITS-1:0] DROP_RESET =
        ((DROP_RAW >> DROP_BITS) != 64'd0) ? {DROP_BITS{1'b1}} : DROP_RAW[DROP_BITS-1:0];

    localparam logic [VOLTAGE_BITS-1:0] V_MAX = {1'b0, {(VOLTAGE_BITS-1){1'b1}}};
    localparam logic [VOLTAGE_BITS-1:0] V_MIN = {1'b1, {(VOLTAGE_BITS-1){1'b0}}};

    // Configuration
    logic [DROP_BITS-1:0] drop_reg;
    logic [COEF_BITS-1:0] leak_reg;
    logic [COEF_BITS-1:0] couple_reg;
    logic [COEF_BITS-1:0] charge_reg;
    logic [COEF_BITS-1:0] load_reg;
    logic [COEF_BITS-1:0] decay_reg;

    // State and working registers
    logic signed [VOLTAGE_BITS-1:0] node1_reg;
    logic signed [VOLTAGE_BITS-1:0] node2_reg;
    logic signed [VOLTAGE_BITS-1:0] node3_reg;
    logic signed [AW-1:0]           acc_reg;
    logic signed [AW-1:0]           acc_next;
    logic                           on_reg;
    logic signed [PHW-1:0]          p_hi_reg;
    logic [COEF_BITS-1:0]           p_lo_reg;
    logic                           prod_valid_reg;
    logic                           prod_sub_reg;

    // Output register
    logic                           out_valid_reg;
    logic signed [VOLTAGE_BITS-1:0] out_node1_reg;
    logic signed [VOLTAGE_BITS-1:0] out_node2_reg;
    logic signed [VOLTAGE_BITS-1:0] out_node3_reg;
    logic                           out_cond_reg;

    logic signed [XW-1:0]           ext1;
    logic signed [XW-1:0]           ext2;
    logic signed [XW-1:0]           ext3;
    logic signed [XW-1:0]           diff;
    logic [COEF_BITS-1:0]           coef_sel;
    logic signed [PHW-1:0]          hi_prod;
    logic [2*COEF_BITS-1:0]         lo_prod;
    logic signed [AW-1:0]           term;
    logic signed [AW-1:0]           am_ext;
    logic signed [AW-1:0]           drop_ext;
    logic signed [AW-1:0]           v1_acc;
    logic signed [AW-1:0]           gap;
    logic                           on_now;
    logic [AW-VOLTAGE_BITS:0]       acc_top;
    logic signed [VOLTAGE_BITS-1:0] sat_val;

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_reg   <= DROP_RESET;
            leak_reg   <= NODE1_LEAK_RESET;
            couple_reg <= NODE1_COUPLE_RESET;
            charge_reg <= NODE2_CHARGE_RESET;
            load_reg   <= NODE2_LOAD_RESET;
            decay_reg  <= NODE3_DECAY_RESET;
        end
        else if (write_en)
        begin
            case (reg_index)
                REG_DROP:         drop_reg   <= write_data;
                REG_NODE1_LEAK:   leak_reg   <= write_data[COEF_BITS-1:0];
                REG_NODE1_COUPLE: couple_reg <= write_data[COEF_BITS-1:0];
                REG_NODE2_CHARGE: charge_reg <= write_data[COEF_BITS-1:0];
                REG_NODE2_LOAD:   load_reg   <= write_data[COEF_BITS-1:0];
                REG_NODE3_DECAY:  decay_reg  <= write_data[COEF_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Diode decision and accumulator start value
    assign am_ext   = {{(AW-VOLTAGE_BITS){am_sample[VOLTAGE_BITS-1]}}, am_sample};
    assign drop_ext = {{(AW-DROP_BITS){1'b0}}, drop_reg};
    assign v1_acc   = {{(AW-VOLTAGE_BITS){node1_reg[VOLTAGE_BITS-1]}}, node1_reg};
    assign gap      = am_ext - v1_acc;
    assign on_now   = (gap > drop_ext);

    // Multiplier operands
    assign ext1 = {{(XW-VOLTAGE_BITS){node1_reg[VOLTAGE_BITS-1]}}, node1_reg};
    assign ext2 = {{(XW-VOLTAGE_BITS){node2_reg[VOLTAGE_BITS-1]}}, node2_reg};
    assign ext3 = {{(XW-VOLTAGE_BITS){node3_reg[VOLTAGE_BITS-1]}}, node3_reg};

    always_comb
    begin
        case (cmd.dsel)
            DIFF_N1:  diff = ext1;
            DIFF_N12: diff = ext1 - ext2;
            DIFF_N3:  diff = ext3;
            default:  diff = ext1;
        endcase
        case (cmd.csel)
            CSEL_LEAK:   coef_sel = leak_reg;
            CSEL_COUPLE: coef_sel = couple_reg;
            CSEL_CHARGE: coef_sel = charge_reg;
            CSEL_LOAD:   coef_sel = load_reg;
            CSEL_DECAY:  coef_sel = decay_reg;
            default:     coef_sel = leak_reg;
        endcase
    end

    // floor(d*c/2^32) = dh*c + floor(dl*c/2^32), dh the signed upper part
    assign hi_prod = $signed(diff[XW-1:COEF_BITS]) * $signed({1'b0, coef_sel});
    assign lo_prod = {{COEF_BITS{1'b0}}, diff[COEF_BITS-1:0]}
                   * {{COEF_BITS{1'b0}}, coef_sel};
    assign term    = {{(AW-PHW){p_hi_reg[PHW-1]}}, p_hi_reg}
                   + $signed({{(AW-COEF_BITS){1'b0}}, p_lo_reg});

    always_comb
    begin
        case (cmd.acc_sel)
            ACC_START: acc_next = on_now ? (am_ext - drop_ext) : v1_acc;
            ACC_N2:    acc_next = {{(AW-VOLTAGE_BITS){node2_reg[VOLTAGE_BITS-1]}}, node2_reg};
            ACC_N3:    acc_next = {{(AW-VOLTAGE_BITS){node3_reg[VOLTAGE_BITS-1]}}, node3_reg};
            default:
            begin
                if (prod_valid_reg)
                begin
                    acc_next = prod_sub_reg ? (acc_reg - term) : (acc_reg + term);
                end
                else
                begin
                    acc_next = acc_reg;
                end
            end
        endcase
    end

    // Saturate the accumulator to the voltage range
    assign acc_top = acc_reg[AW-1:VOLTAGE_BITS-1];
    always_comb
    begin
        if ((&acc_top) || !(|acc_top))
        begin
            sat_val = acc_reg[VOLTAGE_BITS-1:0];
        end
        else
        begin
            sat_val = acc_reg[AW-1] ? V_MIN : V_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        p_hi_reg <= hi_prod;
        p_lo_reg <= lo_prod[2*COEF_BITS-1:COEF_BITS];
        prod_sub_reg <= cmd.mul_sub;
        if (cmd.capture)
        begin
            on_reg <= on_now;
        end
        if (cmd.commit == COMMIT_N3)
        begin
            out_node1_reg <= node1_reg;
            out_node2_reg <= node2_reg;
            out_node3_reg <= sat_val;
            out_cond_reg  <= on_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node1_reg      <= '0;
            node2_reg      <= '0;
            node3_reg      <= '0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= cmd.mul_go;
            case (cmd.commit)
                COMMIT_N1: node1_reg <= sat_val;
                COMMIT_N2: node2_reg <= sat_val;
                COMMIT_N3: node3_reg <= sat_val;
                default:   ;
            endcase
            if (cmd.commit == COMMIT_N3)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.on       = on_now;
    assign status.out_busy = out_valid_reg && !results.ready;

    assign results.valid      = out_valid_reg;
    assign results.node1_out  = out_node1_reg;
    assign results.node2_out  = out_node2_reg;
    assign results.node3_out  = out_node3_reg;
    assign results.conducting = out_cond_reg;

    `DED_ASSERT_IMP(a_no_load_over_term, prod_valid_reg, cmd.acc_sel == ACC_HOLD, "accumulator load would drop a pending product")
    `DED_ASSERT_IMP(a_commit_complete, cmd.commit != COMMIT_NONE, !prod_valid_reg, "node committed with a product still pending")
    `DED_ASSERT_IMP(a_no_overwrite, cmd.commit == COMMIT_N3, !(out_valid_reg && !results.ready), "result overwritten before transfer")

endmodule

>>> rtl/core/diode_envelope_detector_step.sv
// ----------------------------------------------------------------------------
// diode_envelope_detector_step
// Three-node diode envelope detector, one forward Euler step per sample.
// ----------------------------------------------------------------------------
// Usage:
//   samples  - valid/ready sink; one am_sample per transfer, signed Q8.32.
//   results  - valid/ready source; one result per sample: the three new node
//              voltages, saturated, and the conducting flag.
//   write_en / reg_index / write_data - register writes, taken at any edge
//              with write_en high; write only while the block is idle.
// Timing: a sample that makes the diode conduct is loaded into the result
//   register sooner than one that does not, since it skips the node 1 decay
//   terms. The delay comes from the single
//   shared multiplier (one product term issued per cycle, six terms per step,
//   four when the diode conducts, each registered before it is accumulated)
//   and from each node waiting for the node before it. The next sample is
//   taken in the cycle after the result is loaded, not while a step is in work.
// Reset: node voltages clear to zero, registers return to their defaults,
//   no result is pending.
// Stall: a result waits in the output register while the next sample is
//   taken and worked; that sample holds at its final commit until the
//   waiting result has been transferred.
// ----------------------------------------------------------------------------
module diode_envelope_detector_step
    import ded_pkg::*;
#(
    parameter int VOLTAGE_BITS  = 40,
    parameter int FRACTION_BITS = 32
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      write_en,
    input  logic [CFG_INDEX_BITS-1:0] reg_index,
    input  logic [CFG_DATA_BITS-1:0]  write_data,
    ded_sample_if.sink                samples,
    ded_result_if.source              results
);

    // Commands from the sequencer, status back from the datapath
    cmd_t  cmd;
    stat_t status;

    // Sequencer: walks node 1, node 2, node 3 in order
    ded_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: registers, multiplier, accumulator and result register
    ded_datapath #(
        .VOLTAGE_BITS  (VOLTAGE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .write_en   (write_en),
        .reg_index  (reg_index),
        .write_data (write_data),
        .am_sample  (samples.am_sample),
        .cmd        (cmd),
        .status     (status),
        .results    (results)
    );

endmodule
